// File: hdl/tmcw_pkg.sv
// Shared types, codes and constants of the text-mode console writer.
package tmcw_pkg;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;
  localparam int QUEUE_DEPTH = 2;
  localparam int TAB_STEP    = 4;

  localparam logic [7:0] FILL_RESET = 8'h07;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_RETURN  = 8'h0D;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_BLANK   = 8'h00;

  localparam logic [1:0] ACT_PUT   = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;
  localparam logic [1:0] ACT_NONE  = 2'd3;

  typedef enum logic [2:0] {
    CMD_CHAR,
    CMD_NEWLINE,
    CMD_RETURN,
    CMD_TAB,
    CMD_CLEAR,
    CMD_READ,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  code;
    logic [10:0] index;
  } cmd_t;

  typedef struct packed {
    logic [10:0] cursor_pos;
    logic [7:0]  read_char;
    logic [7:0]  read_color;
  } res_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_TAB,
    ST_COPY,
    ST_FILL,
    ST_CLEAR,
    ST_READ,
    ST_REPORT
  } eng_state_t;

endpackage

// File: hdl/tmcw_fifo.sv
// Small register queue used between the front, the engine and the result port.
module tmcw_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         empty
);

  localparam int PW   = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [W-1:0]    mem [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CNTW-1:0] count;
  logic            wr_ok;
  logic            rd_ok;

  assign full    = (count == CNTW'(DEPTH));
  assign empty   = (count == '0);
  assign wr_ok   = wr_en && !full;
  assign rd_ok   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_ok) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_ok) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_ok && !rd_ok) begin
        count <= count + 1'b1;
      end else if (rd_ok && !wr_ok) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: hdl/tmcw_front.sv
// Front end: classifies incoming requests and queues them for the engine.
module tmcw_front import tmcw_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        hold,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  action,
  input  logic [7:0]  char_code,
  input  logic [10:0] cell_index,
  output logic        cmd_valid,
  output cmd_t        cmd,
  input  logic        cmd_pop
);

  localparam int CELLS = COLUMNS * ROWS;

  cmd_t kind_cmd;
  logic q_full;
  logic q_empty;

  // Control bytes are recognized here so the engine only sees cmd kinds.
  always_comb begin
    kind_cmd.code  = char_code;
    kind_cmd.index = cell_index;
    unique case (action)
      ACT_PUT: begin
        unique case (char_code)
          CH_NEWLINE: kind_cmd.kind = CMD_NEWLINE;
          CH_RETURN:  kind_cmd.kind = CMD_RETURN;
          CH_TAB:     kind_cmd.kind = CMD_TAB;
          default:    kind_cmd.kind = CMD_CHAR;
        endcase
      end
      ACT_CLEAR: kind_cmd.kind = CMD_CLEAR;
      ACT_READ: begin
        kind_cmd.kind = (32'(cell_index) < 32'(CELLS)) ? CMD_READ : CMD_NOP;
      end
      default: kind_cmd.kind = CMD_NOP;
    endcase
  end

  assign full      = q_full || hold;
  assign cmd_valid = !q_empty;

  tmcw_fifo #(
    .W     ($bits(cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push && !hold),
    .wr_data (kind_cmd),
    .full    (q_full),
    .rd_en   (cmd_pop),
    .rd_data (cmd),
    .empty   (q_empty)
  );

endmodule

// File: hdl/tmcw_engine.sv
// Back end: cursor, cell stores, scroll and clear sweeps, result generation.
module tmcw_engine import tmcw_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  input  cmd_t       cmd,
  output logic       cmd_pop,
  input  logic [7:0] fill_color,
  input  logic       res_full,
  output logic       res_push,
  output res_t       res,
  output logic       init_busy
);

  localparam int CELLS    = COLUMNS * ROWS;
  localparam int AW       = $clog2(CELLS);
  localparam int SW       = $clog2(CELLS + 1);
  localparam int CW       = $clog2(COLUMNS);
  localparam int RW       = $clog2(ROWS);
  localparam int COPY_END = CELLS - COLUMNS;

  eng_state_t state;
  eng_state_t state_next;

  logic [7:0]    chars  [CELLS];
  logic [7:0]    colors [CELLS];
  logic [7:0]    rd_char_q;
  logic [7:0]    rd_color_q;
  logic [SW-1:0] sweep;
  logic [SW-1:0] sweep_next;
  logic [CW-1:0] col;
  logic [CW-1:0] col_next;
  logic [RW-1:0] row;
  logic [RW-1:0] row_next;
  logic [7:0]    res_char;
  logic [7:0]    res_char_next;
  logic [7:0]    res_color;
  logic [7:0]    res_color_next;

  logic          ch_we;
  logic          co_we;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_char;
  logic [7:0]    wr_color;
  logic [AW-1:0] rd_addr;

  logic [AW-1:0] cur_addr;
  logic [CW:0]   col_inc;
  logic [RW:0]   row_inc;
  logic          wrap;
  logic          row_over;
  logic          adv_over;
  logic [CW-1:0] adv_col;
  logic [RW-1:0] adv_row;
  logic          tab_stop;
  logic          sweep_last;

  assign cur_addr = AW'(row) * AW'(COLUMNS) + AW'(col);
  assign col_inc  = {1'b0, col} + 1'b1;
  assign row_inc  = {1'b0, row} + 1'b1;
  assign wrap     = (col_inc >= (CW + 1)'(COLUMNS));
  assign row_over = (row_inc >= (RW + 1)'(ROWS));
  assign adv_over = wrap && row_over;
  assign adv_col  = wrap ? '0 : col_inc[CW-1:0];
  // On overflow the cursor stays on the bottom row while the grid scrolls.
  assign adv_row  = (wrap && !row_over) ? row_inc[RW-1:0] : row;
  assign tab_stop = wrap || ((col_inc & (CW + 1)'(TAB_STEP - 1)) == '0);
  assign sweep_last = (sweep == SW'(CELLS - 1));

  assign init_busy = (state == ST_INIT);
  assign res.cursor_pos = 11'(cur_addr);
  assign res.read_char  = res_char;
  assign res.read_color = res_color;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state) inside
      ST_INIT: begin
        if (sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.kind)
            CMD_CHAR:    state_next = adv_over ? ST_COPY : ST_REPORT;
            CMD_NEWLINE: state_next = row_over ? ST_COPY : ST_REPORT;
            CMD_TAB:     state_next = ST_TAB;
            CMD_CLEAR:   state_next = ST_CLEAR;
            CMD_READ:    state_next = ST_READ;
            default:     state_next = ST_REPORT;
          endcase
        end
      end
      ST_TAB: begin
        if (adv_over) begin
          state_next = ST_COPY;
        end else if (tab_stop) begin
          state_next = ST_REPORT;
        end
      end
      ST_COPY: begin
        if (sweep == SW'(COPY_END)) begin
          state_next = ST_FILL;
        end
      end
      ST_FILL, ST_CLEAR: begin
        if (sweep_last) begin
          state_next = ST_REPORT;
        end
      end
      ST_READ: state_next = ST_REPORT;
      ST_REPORT: begin
        if (!res_full) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath controls and register next values.
  always_comb begin
    cmd_pop        = 1'b0;
    res_push       = 1'b0;
    ch_we          = 1'b0;
    co_we          = 1'b0;
    wr_addr        = cur_addr;
    wr_char        = CH_BLANK;
    wr_color       = fill_color;
    rd_addr        = '0;
    col_next       = col;
    row_next       = row;
    sweep_next     = sweep;
    res_char_next  = res_char;
    res_color_next = res_color;
    unique case (state) inside
      ST_INIT: begin
        ch_we      = 1'b1;
        co_we      = 1'b1;
        wr_addr    = AW'(sweep);
        wr_color   = FILL_RESET;
        sweep_next = sweep + 1'b1;
      end
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop        = 1'b1;
          res_char_next  = '0;
          res_color_next = '0;
          sweep_next     = '0;
          case (cmd.kind)
            CMD_CHAR: begin
              ch_we    = 1'b1;
              wr_char  = cmd.code;
              col_next = adv_col;
              row_next = adv_row;
            end
            CMD_NEWLINE: begin
              col_next = '0;
              row_next = row_over ? row : row_inc[RW-1:0];
            end
            CMD_RETURN: col_next = '0;
            CMD_CLEAR: begin
              col_next = '0;
              row_next = '0;
            end
            CMD_READ: rd_addr = AW'(cmd.index);
            default: ;
          endcase
        end
      end
      ST_TAB: begin
        ch_we      = 1'b1;
        wr_char    = CH_SPACE;
        col_next   = adv_col;
        row_next   = adv_row;
        sweep_next = '0;
      end
      ST_COPY: begin
        // Read one row ahead; the previous read lands one cell back.
        if (sweep != SW'(COPY_END)) begin
          rd_addr    = AW'(sweep + SW'(COLUMNS));
          sweep_next = sweep + 1'b1;
        end
        if (sweep != '0) begin
          ch_we    = 1'b1;
          co_we    = 1'b1;
          wr_addr  = AW'(sweep - 1'b1);
          wr_char  = rd_char_q;
          wr_color = rd_color_q;
        end
      end
      ST_FILL, ST_CLEAR: begin
        ch_we      = 1'b1;
        co_we      = 1'b1;
        wr_addr    = AW'(sweep);
        sweep_next = sweep + 1'b1;
      end
      ST_READ: begin
        res_char_next  = rd_char_q;
        res_color_next = rd_color_q;
      end
      ST_REPORT: res_push = !res_full;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ch_we) begin
      chars[wr_addr] <= wr_char;
    end
    if (co_we) begin
      colors[wr_addr] <= wr_color;
    end
    rd_char_q  <= chars[rd_addr];
    rd_color_q <= colors[rd_addr];
  end

  always_ff @(posedge clk) begin
    res_char  <= res_char_next;
    res_color <= res_color_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      sweep <= '0;
      col   <= '0;
      row   <= '0;
    end else begin
      state <= state_next;
      sweep <= sweep_next;
      col   <= col_next;
      row   <= row_next;
    end
  end

endmodule

// File: hdl/text_mode_console_writer.sv
// Top level of the text-mode console writer: front, engine and result queue.
//
//  Channel    | Handshake              | Payload
//  -----------+------------------------+--------------------------------------
//  request in | push / full            | action, char_code, cell_index
//  result out | pop / empty            | cursor_pos, read_char, read_color
//  config     | fill_color_we          | fill_color_wdata
//
// A printable byte, carriage return, newline or an idle action goes straight
// from idle to report, a cell read passes through the read state, and a tab
// writes one space per step of the tab state (at most 4 spaces). A scroll copies
// each row up and fills the bottom row, and a clear fills every cell: both sweep
// the grid through the single write port of the cell stores. After reset a
// clearing pass runs with full held high; configuration writes are taken during
// it. Two-entry queues on either side let requests queue up while results wait.
module text_mode_console_writer import tmcw_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  action,
  input  logic [7:0]  char_code,
  input  logic [10:0] cell_index,
  output logic        empty,
  input  logic        pop,
  output logic [10:0] cursor_pos,
  output logic [7:0]  read_char,
  output logic [7:0]  read_color,
  input  logic        fill_color_we,
  input  logic [7:0]  fill_color_wdata
);

  localparam int CELLS = COLUMNS * ROWS;

  logic [7:0] fill_color;
  logic       cmd_valid;
  cmd_t       cmd;
  logic       cmd_pop;
  logic       res_push;
  logic       res_full;
  res_t       res_in;
  res_t       res_out;
  logic       init_busy;

  // The fill attribute is used by clears and by the line that scrolls in.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_color <= FILL_RESET;
    end else if (fill_color_we) begin
      fill_color <= fill_color_wdata;
    end
  end

  // Front: classifies each request and holds it until the engine is free.
  tmcw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .hold       (init_busy),
    .push       (push),
    .full       (full),
    .action     (action),
    .char_code  (char_code),
    .cell_index (cell_index),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop)
  );

  // Engine: owns the cursor and the cell stores and runs the sweeps.
  tmcw_engine #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .fill_color (fill_color),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (res_in),
    .init_busy  (init_busy)
  );

  // Result queue decouples the engine from a stalled consumer.
  tmcw_fifo #(
    .W     ($bits(res_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res_in),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_out),
    .empty   (empty)
  );

  assign cursor_pos = res_out.cursor_pos;
  assign read_char  = res_out.read_char;
  assign read_color = res_out.read_color;

`ifndef SYNTHESIS
  // The engine never offers a result the queue cannot take.
  a_no_res_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

  // The engine only takes a request that is actually queued.
  a_pop_has_cmd: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> cmd_valid)
    else $error("request taken from an empty queue");

  // No request enters while the clearing pass runs.
  a_init_blocks: assert property (@(posedge clk) disable iff (rst)
    init_busy |-> full)
    else $error("request accepted during clearing pass");

  // A reported cursor always lies on the grid.
  a_cursor_on_grid: assert property (@(posedge clk) disable iff (rst)
    res_push |-> (32'(res_in.cursor_pos) < 32'(CELLS)))
    else $error("cursor off the grid");
`endif

endmodule

// File: test/text_mode_console_writer_test.sv
// Self-checking testbench of the text-mode console writer, with its own model of grid and cursor.
module text_mode_console_writer_test import tmcw_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // Geometry of the instance under test; the block is built with its defaults.
  localparam int COLUMNS = DEF_COLUMNS;
  localparam int ROWS    = DEF_ROWS;
  localparam int CELLS   = COLUMNS * ROWS;

  // Every sweep ends before its result goes out, so the engine is idle once the last
  // result is taken; this margin before a fill attribute write is generous.
  localparam int SETTLE_CYCLES = CELLS + 32;

  // Every input of the block starts from a known value.
  logic        clk              = 1'b0;
  logic        rst              = 1'b1;
  logic        push             = 1'b0;
  logic        full;
  logic [1:0]  action           = ACT_PUT;
  logic [7:0]  char_code        = 8'h00;
  logic [10:0] cell_index       = 11'd0;
  logic        empty;
  logic        pop              = 1'b0;
  logic [10:0] cursor_pos;
  logic [7:0]  read_char;
  logic [7:0]  read_color;
  logic        fill_color_we    = 1'b0;
  logic [7:0]  fill_color_wdata = 8'h00;

  // Model of the console: character grid, attribute grid, cursor and fill attribute.
  logic [7:0]  screen_chars [CELLS];
  logic [7:0]  screen_colors [CELLS];
  int unsigned cur_col;
  int unsigned cur_row;
  logic [7:0]  fill_model;

  // Reports predicted for accepted requests, oldest first.
  res_t pending_reports [$];
  int   error_count = 0;

  // When set, neither side inserts idle cycles.
  bit   calm = 1'b0;
  int   pop_stall = 0;

  text_mode_console_writer i_dut (
    .clk              (clk),
    .rst              (rst),
    .push             (push),
    .full             (full),
    .action           (action),
    .char_code        (char_code),
    .cell_index       (cell_index),
    .empty            (empty),
    .pop              (pop),
    .cursor_pos       (cursor_pos),
    .read_char        (read_char),
    .read_color       (read_color),
    .fill_color_we    (fill_color_we),
    .fill_color_wdata (fill_color_wdata)
  );

  initial begin : clock_gen
    forever #5ns clk = ~clk;
  end

  // Idle length for either side: mostly none or a few cycles, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Wrap past the last column, and scroll the grid up one line past the last row.
  // The scrolled-in bottom line is blank in the current fill attribute.
  function automatic void settle_cursor();
    if (cur_col >= COLUMNS) begin
      cur_col = 0;
      cur_row++;
    end
    if (cur_row >= ROWS) begin
      for (int i = 0; i < CELLS - COLUMNS; i++) begin
        screen_chars[i]  = screen_chars[i + COLUMNS];
        screen_colors[i] = screen_colors[i + COLUMNS];
      end
      for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
        screen_chars[i]  = CH_BLANK;
        screen_colors[i] = fill_model;
      end
      cur_row = ROWS - 1;
    end
  endfunction

  // A written byte keeps the attribute of its cell and moves the cursor on.
  function automatic void write_cell(logic [7:0] code);
    screen_chars[cur_row * COLUMNS + cur_col] = code;
    cur_col++;
    settle_cursor();
  endfunction

  function automatic void clear_screen_model();
    foreach (screen_chars[i]) begin
      screen_chars[i]  = CH_BLANK;
      screen_colors[i] = fill_model;
    end
    cur_col = 0;
    cur_row = 0;
  endfunction

  // Applies one request to the model and returns the report it should produce.
  function automatic res_t predict_console(logic [1:0] act, logic [7:0] code,
                                           logic [10:0] idx);
    res_t rep;
    rep.read_char  = 8'h00;
    rep.read_color = 8'h00;
    case (act)
      ACT_PUT: begin
        if (code == CH_NEWLINE) begin
          cur_col = 0;
          cur_row++;
          settle_cursor();
        end else if (code == CH_RETURN) begin
          cur_col = 0;
        end else if (code == CH_TAB) begin
          // A tab always writes at least one space, then stops on a tab stop;
          // a tab that wraps therefore ends at column 0 of the next row.
          do begin
            write_cell(CH_SPACE);
          end while ((cur_col % TAB_STEP) != 0);
        end else begin
          write_cell(code);
        end
      end
      ACT_CLEAR: clear_screen_model();
      ACT_READ: begin
        // A read beyond the grid returns zeros and changes nothing.
        if (idx < CELLS) begin
          rep.read_char  = screen_chars[idx];
          rep.read_color = screen_colors[idx];
        end
      end
      default: ;  // The unused action only reports the cursor.
    endcase
    rep.cursor_pos = 11'(cur_row * COLUMNS + cur_col);
    return rep;
  endfunction

  // Sends one request. Push is only lowered when an idle gap comes first, so that a
  // back-to-back request never sees push lowered and raised in the same time step.
  // The request is taken at the first edge where full was low.
  task automatic issue_request(logic [1:0] act, logic [7:0] code, logic [10:0] idx);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push       <= 1'b1;
    action     <= act;
    char_code  <= code;
    cell_index <= idx;
    @(posedge clk);
    while (full) @(posedge clk);
    pending_reports.push_back(predict_console(act, code, idx));
  endtask

  // Stops sending, waits for every predicted report, then adds a safety margin.
  task automatic wait_idle();
    push <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Each accepted report is compared with the oldest prediction. Signals are sampled
  // just after the edge, so they hold the values the block saw at that edge.
  always @(posedge clk) begin : report_check
    res_t want;
    if (!rst && pop && !empty) begin
      if (pending_reports.size() == 0) begin
        $error("report with no pending request: cursor_pos %0d read_char %0h read_color %0h",
               cursor_pos, read_char, read_color);
        error_count++;
      end else begin
        want = pending_reports.pop_front();
        if (cursor_pos !== want.cursor_pos) begin
          $error("cursor_pos expected %0d actual %0d", want.cursor_pos, cursor_pos);
          error_count++;
        end
        if (read_char !== want.read_char) begin
          $error("read_char expected %0h actual %0h", want.read_char, read_char);
          error_count++;
        end
        if (read_color !== want.read_color) begin
          $error("read_color expected %0h actual %0h", want.read_color, read_color);
          error_count++;
        end
      end
    end
    // The result side stalls in runs of random length.
    if (pop_stall > 0) begin
      pop <= 1'b0;
      pop_stall--;
    end else begin
      pop <= 1'b1;
      if ($urandom_range(0, 3) == 0) pop_stall = pick_gap();
    end
  end

  // Mostly printable text, with some tabs, newlines, returns and arbitrary bytes.
  function automatic logic [7:0] text_byte();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 8)  return CH_TAB;
    if (roll < 12) return CH_NEWLINE;
    if (roll < 15) return CH_RETURN;
    if (roll < 20) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(8'h20, 8'h7E));
  endfunction

  // Right after reset the grid is blank in the reset attribute.
  task automatic test_reset_state();
    issue_request(ACT_READ, 8'h00, 11'd0);
    issue_request(ACT_READ, 8'hFF, 11'(CELLS - 1));
    issue_request(ACT_NONE, 8'hFF, 11'h7FF);
  endtask

  // Ordinary bytes at both ends of the range, the shortest and longest tab, return and newline,
  // then read back what was written.
  task automatic test_put_bytes();
    issue_request(ACT_PUT, 8'h41, 11'h7FF);
    issue_request(ACT_PUT, 8'h00, 11'd0);
    issue_request(ACT_PUT, 8'hFF, 11'd0);
    issue_request(ACT_PUT, CH_TAB, 11'd0);
    issue_request(ACT_PUT, CH_TAB, 11'd0);
    issue_request(ACT_PUT, 8'h08, 11'd0);
    issue_request(ACT_PUT, CH_RETURN, 11'd0);
    issue_request(ACT_PUT, CH_NEWLINE, 11'd0);
    issue_request(ACT_PUT, 8'h7E, 11'd0);
    issue_request(ACT_READ, 8'h00, 11'd0);
    issue_request(ACT_READ, 8'h00, 11'd2);
    issue_request(ACT_READ, 8'h00, 11'd5);
    issue_request(ACT_READ, 8'h00, 11'd4);
    issue_request(ACT_READ, 8'h00, 11'(COLUMNS));
  endtask

  // Reads at the last cell, just beyond it and at the top of the index range.
  task automatic test_read_bounds();
    issue_request(ACT_READ, 8'h00, 11'(CELLS));
    issue_request(ACT_READ, 8'h00, 11'h7FF);
    issue_request(ACT_READ, 8'h00, 11'(CELLS - 1));
    issue_request(ACT_NONE, 8'h00, 11'(CELLS));
  endtask

  // Writes the fill attribute while idle. With wipe set the screen is cleared at once;
  // otherwise old attributes stay and only scrolled-in lines take the new one.
  task automatic test_fill_color(logic [7:0] color, bit wipe);
    wait_idle();
    fill_color_we    <= 1'b1;
    fill_color_wdata <= color;
    @(posedge clk);
    fill_color_we <= 1'b0;
    fill_model = color;
    if (wipe) begin
      issue_request(ACT_CLEAR, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
      issue_request(ACT_READ, 8'h00, 11'(CELLS - 1));
    end
  endtask

  // Random console traffic in bursts: runs of text, runs heavy in newlines that push
  // the cursor to the bottom and scroll, runs of reads, and an occasional clear.
  task automatic test_console_traffic(int count);
    int sent;
    int kind;
    int run;
    int roll;
    int spot;
    logic [7:0]  code;
    logic [10:0] idx;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(0, 99);
      run  = $urandom_range(4, 40);
      calm = ($urandom_range(0, 9) == 0);
      if (kind < 3) begin
        issue_request(ACT_CLEAR, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
        sent++;
      end else begin
        for (int k = 0; k < run && sent < count; k++) begin
          idx  = 11'($urandom_range(0, 2047));
          code = 8'($urandom_range(0, 255));
          roll = $urandom_range(0, 99);
          if (kind < 25) begin
            issue_request(ACT_PUT, (roll < 60) ? CH_NEWLINE : text_byte(), idx);
          end else if (kind < 45) begin
            if (roll < 45) begin
              // Just behind the cursor, where the latest bytes landed.
              spot = int'(cur_row) * COLUMNS + int'(cur_col) - int'($urandom_range(0, 160));
              if (spot < 0) spot = 0;
              issue_request(ACT_READ, code, 11'(spot));
            end else if (roll < 75) begin
              issue_request(ACT_READ, code, 11'($urandom_range(0, CELLS - 1)));
            end else if (roll < 85) begin
              // The bottom line holds scrolled-in cells.
              issue_request(ACT_READ, code, 11'($urandom_range(CELLS - COLUMNS, CELLS - 1)));
            end else if (roll < 93) begin
              issue_request(ACT_READ, code, 11'($urandom_range(CELLS, 2047)));
            end else begin
              issue_request(ACT_NONE, code, idx);
            end
          end else begin
            issue_request(ACT_PUT, text_byte(), idx);
          end
          sent++;
        end
      end
    end
    calm = 1'b0;
  endtask

  initial begin : run_tests
    fill_model = FILL_RESET;
    clear_screen_model();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_put_bytes();
    test_read_bounds();

    test_fill_color(8'h00, 1'b1);
    test_console_traffic(390);
    test_fill_color(8'hFF, 1'b0);
    test_console_traffic(390);
    test_fill_color(8'($urandom_range(1, 254)), 1'b1);
    test_console_traffic(390);
    test_fill_color(8'hA5, 1'b0);
    test_console_traffic(390);
    test_fill_color(FILL_RESET, 1'b1);
    test_console_traffic(370);

    wait_idle();
    if (error_count == 0) begin
      $display("text_mode_console_writer_test OK");
    end else begin
      $display("text_mode_console_writer_test NOT OK");
    end
    $finish;
  end

  // Ends a run that hangs, far beyond the slowest correct run.
  initial begin : watchdog
    #200ms;
    $display("text_mode_console_writer_test NOT OK");
    $finish;
  end

endmodule
